// ===== hw/rtl/longest_prefix_route_table_core_defines.svh =====
// Assertion macros used by the route table checker.
`ifndef LONGEST_PREFIX_ROUTE_TABLE_CORE_DEFINES_SVH
`define LONGEST_PREFIX_ROUTE_TABLE_CORE_DEFINES_SVH

// Property checked only outside reset.
`define LPRT_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every edge, reset included.
`define LPRT_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/lprt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lprt_pkg;

   localparam int DEF_ENTRIES = 32;
   localparam int ADDR_W      = 32;
   localparam int CARD_W      = 4;
   localparam int LEN_W       = 6;
   localparam int USED_W      = 6;

   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_ADD    = 2'd1,
      CMD_LOOKUP = 2'd2,
      CMD_NOP    = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD_NET,
      ST_ADD_DEF,
      ST_LOOKUP,
      ST_EMIT
   } state_type;

   typedef struct packed {
      cmd_type             command;
      logic [ADDR_W-1:0]   address;
      logic [ADDR_W-1:0]   mask_in;
      logic [CARD_W-1:0]   card;
   } req_type;

   typedef struct packed {
      logic                found;
      logic [CARD_W-1:0]   card_out;
      logic                table_full;
      logic [USED_W-1:0]   entries_used;
   } rsp_type;

   // One stored route.
   typedef struct packed {
      logic [ADDR_W-1:0]   net;
      logic [ADDR_W-1:0]   mask;
      logic [LEN_W-1:0]    len;
      logic [CARD_W-1:0]   card;
   } route_type;

   // Prefix length of a mask: nibble counts, then a sum of eight.
   function automatic logic [LEN_W-1:0] mask_len(input logic [ADDR_W-1:0] m);
      logic [2:0]       nib [8];
      logic [LEN_W-1:0] sum;
      for (int i = 0; i < 8; i++) begin
         nib[i] = 3'({2'b0, m[4*i]}) + 3'({2'b0, m[4*i+1]})
                + 3'({2'b0, m[4*i+2]}) + 3'({2'b0, m[4*i+3]});
      end
      sum = '0;
      for (int i = 0; i < 8; i++) begin
         sum = sum + LEN_W'(nib[i]);
      end
      return sum;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lprt_route_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lprt_route_ram
   import lprt_pkg::*;
#(
   parameter int DEPTH = DEF_ENTRIES
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire route_type                wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output route_type                     rd_data
);

   route_type mem [DEPTH];
   route_type rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/longest_prefix_route_table_core.sv =====
// Route table with longest-prefix lookup, one command in flight at a time.
// Clear and no-op go straight to the result; add writes the route, then a default route
// when the gateway matches; lookup scans the stored routes, one route memory read per cycle,
// and the result waits while the previous result is still held by rsp_stall.
// The next command is taken while a result waits.
// Synchronous active-high reset empties the table, zeroes the gateway and drops results.
`timescale 1ns / 1ps
`default_nettype none

module longest_prefix_route_table_core
   import lprt_pkg::*;
#(
   parameter int ENTRIES = DEF_ENTRIES
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire req_type           req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output rsp_type                rsp_data,
   input  wire logic              csr_wr_en,
   input  wire logic [ADDR_W-1:0] csr_wr_data
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);

   state_type         state_ff, state_in;
   req_type           req_ff, req_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  iss_ff, iss_in;
   logic              pend_ff, pend_in;
   logic [ADDR_W-1:0] gw_ff;
   logic              found_ff, found_in;
   logic [CARD_W-1:0] card_ff, card_in;
   logic              full_ff, full_in;
   logic [LEN_W-1:0]  best_ff, best_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              wr_en, rd_en;
   logic [IDX_W-1:0]  wr_addr, rd_addr;
   route_type         wr_data, rd_data;

   logic              req_xfer;
   logic              has_room;
   logic              gw_hit;
   logic              route_hit;
   logic [CNT_W+USED_W-1:0] used_ext;

   lprt_route_ram #(.DEPTH(ENTRIES)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign has_room  = (count_ff < CNT_W'(ENTRIES));
   assign gw_hit    = (gw_ff != '0)
                   && ((gw_ff & req_ff.mask_in) == (req_ff.address & req_ff.mask_in));
   assign route_hit = pend_ff
                   && ((req_ff.address & rd_data.mask) == rd_data.net)
                   && (!found_ff || (rd_data.len > best_ff));
   assign used_ext  = {{USED_W{1'b0}}, count_ff};

   // Sequencer: next state, table writes, scan reads, result build
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      count_in     = count_ff;
      iss_in       = iss_ff;
      pend_in      = pend_ff;
      found_in     = found_ff;
      card_in      = card_ff;
      full_in      = full_ff;
      best_in      = best_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = count_ff[IDX_W-1:0];
      wr_data      = '0;
      rd_en        = 1'b0;
      rd_addr      = iss_ff[IDX_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               req_in   = req_data;
               found_in = 1'b0;
               card_in  = '0;
               full_in  = 1'b0;
               best_in  = '0;
               iss_in   = '0;
               pend_in  = 1'b0;
               unique case (req_data.command)
                  CMD_CLEAR: begin
                     count_in = '0;
                     state_in = ST_EMIT;
                  end
                  CMD_ADD:    state_in = ST_ADD_NET;
                  CMD_LOOKUP: state_in = ST_LOOKUP;
                  default:    state_in = ST_EMIT;
               endcase
            end
         end

         ST_ADD_NET: begin
            wr_data.net  = req_ff.address & req_ff.mask_in;
            wr_data.mask = req_ff.mask_in;
            wr_data.len  = mask_len(req_ff.mask_in);
            wr_data.card = req_ff.card;
            if (has_room) begin
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
            end else begin
               full_in  = 1'b1;
            end
            state_in = gw_hit ? ST_ADD_DEF : ST_EMIT;
         end

         ST_ADD_DEF: begin
            // default route: network and mask zero
            wr_data.card = req_ff.card;
            if (has_room) begin
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
            end else begin
               full_in  = 1'b1;
            end
            state_in = ST_EMIT;
         end

         ST_LOOKUP: begin
            // issue one read per cycle, compare the one returned
            if (iss_ff < count_ff) begin
               rd_en   = 1'b1;
               iss_in  = iss_ff + 1'b1;
               pend_in = 1'b1;
            end else begin
               pend_in = 1'b0;
            end
            if (route_hit) begin
               found_in = 1'b1;
               card_in  = rd_data.card;
               best_in  = rd_data.len;
            end
            if ((iss_ff == count_ff) && !pend_ff) begin
               state_in = ST_EMIT;
            end
         end

         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in        = 1'b1;
               rsp_in.found        = found_ff;
               rsp_in.card_out     = card_ff;
               rsp_in.table_full   = full_ff;
               rsp_in.entries_used = used_ext[USED_W-1:0];
               state_in            = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         iss_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         iss_ff       <= iss_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Gateway register
   always_ff @(posedge clock) begin
      if (reset) begin
         gw_ff <= '0;
      end else if (csr_wr_en) begin
         gw_ff <= csr_wr_data;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      found_ff <= found_in;
      card_ff  <= card_in;
      full_ff  <= full_in;
      best_ff  <= best_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/lprt_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "longest_prefix_route_table_core_defines.svh"

module lprt_checker
   import lprt_pkg::*;
#(
   parameter int ENTRIES = DEF_ENTRIES
) (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   // no result survives reset
   `LPRT_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_valid, "result after reset")

   // a stalled request holds until its transfer
   `LPRT_ASSERT(a_req_hold, clock, reset,
      req_valid && req_stall |=> req_valid && $stable(req_data), "stalled request changed")

   // a stalled result holds until its transfer
   `LPRT_ASSERT(a_rsp_hold, clock, reset,
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data), "stalled result changed")

   // card is zero when nothing matched
   `LPRT_ASSERT(a_card_zero, clock, reset,
      rsp_valid && !rsp_data.found |-> rsp_data.card_out == '0, "card without match")

   // route count never exceeds capacity
   `LPRT_ASSERT(a_count_cap, clock, reset,
      rsp_valid |-> (ENTRIES > 63) || (int'(rsp_data.entries_used) <= ENTRIES),
      "count above capacity")

endmodule

bind longest_prefix_route_table_core lprt_checker #(.ENTRIES(ENTRIES)) u_lprt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// ===== tb/tb_longest_prefix_route_table_core.sv =====
`timescale 1ns / 1ps

module tb_longest_prefix_route_table_core;
   import lprt_pkg::*;

   localparam int TABLE_DEPTH  = DEF_ENTRIES;
   localparam int PHASE_ITEMS  = 340;
   localparam int QUIET_LIMIT  = 4000;
   localparam int REPORT_LIMIT = 10;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 40;

   // One row of the directed stimulus; typed rows carry their own expected result
   typedef struct {
      cmd_type     cmd;
      logic [31:0] addr;
      logic [31:0] mask;
      logic [3:0]  card;
      bit          typed;
      rsp_type     want;
   } dir_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_wr_en;
   logic [31:0] csr_wr_data;

   // shadow route table
   logic [31:0] shadow_net  [TABLE_DEPTH];
   logic [31:0] shadow_mask [TABLE_DEPTH];
   logic [5:0]  shadow_len  [TABLE_DEPTH];
   logic [3:0]  shadow_card [TABLE_DEPTH];
   int unsigned shadow_count;
   logic [31:0] shadow_gateway;

   rsp_type     pending_answers [$];
   logic [31:0] subnet_pool [8];

   int          fail_count;
   int          quiet_cycles;
   int          tx_idle_pct;
   int          rx_stall_pct;
   int          rx_hold_left;

   dir_row_type dir_rows [22] = '{
      '{CMD_LOOKUP, 32'hFFFFFFFF, 32'h00000000, 4'd0,  1'b1, {1'b0, 4'd0, 1'b0, 6'd0}},
      '{CMD_NOP,    32'hFFFFFFFF, 32'hFFFFFFFF, 4'd15, 1'b1, {1'b0, 4'd0, 1'b0, 6'd0}},
      '{CMD_ADD,    32'hC0A80117, 32'hFFFFFF00, 4'd15, 1'b1, {1'b0, 4'd0, 1'b0, 6'd1}},
      '{CMD_LOOKUP, 32'h0B000000, 32'hFFFFFFFF, 4'd7,  1'b1, {1'b0, 4'd0, 1'b0, 6'd1}},
      '{CMD_ADD,    32'h0A000005, 32'hFF000000, 4'd1,  1'b1, {1'b0, 4'd0, 1'b0, 6'd3}},
      '{CMD_LOOKUP, 32'h0A010203, 32'h00000000, 4'd0,  1'b0, '0},
      '{CMD_LOOKUP, 32'hC0A80001, 32'h00000000, 4'd0,  1'b0, '0},
      '{CMD_LOOKUP, 32'hC0A801FE, 32'h00000000, 4'd0,  1'b0, '0},
      '{CMD_ADD,    32'h12345678, 32'hFFFFFFFF, 4'd2,  1'b0, '0},
      '{CMD_LOOKUP, 32'h12345678, 32'h00000000, 4'd0,  1'b0, '0},
      '{CMD_ADD,    32'hF0F0F0F0, 32'hF0F0F0F0, 4'd3,  1'b0, '0},
      '{CMD_LOOKUP, 32'hFAF5F3FF, 32'h00000000, 4'd0,  1'b0, '0},
      '{CMD_ADD,    32'h0A0000FF, 32'hFF000000, 4'd5,  1'b0, '0},
      '{CMD_LOOKUP, 32'h0AFFFFFF, 32'h00000000, 4'd0,  1'b0, '0},
      '{CMD_LOOKUP, 32'h00000000, 32'h00000000, 4'd0,  1'b0, '0},
      '{CMD_CLEAR,  32'hFFFFFFFF, 32'hFFFFFFFF, 4'd15, 1'b1, {1'b0, 4'd0, 1'b0, 6'd0}},
      '{CMD_LOOKUP, 32'h0A000001, 32'h00000000, 4'd0,  1'b1, {1'b0, 4'd0, 1'b0, 6'd0}},
      '{CMD_ADD,    32'h00000000, 32'h00000000, 4'd0,  1'b1, {1'b0, 4'd0, 1'b0, 6'd2}},
      '{CMD_LOOKUP, 32'hFFFFFFFF, 32'h00000000, 4'd0,  1'b0, '0},
      '{CMD_ADD,    32'hFFFFFFFF, 32'hFFFFFFFF, 4'd15, 1'b0, '0},
      '{CMD_LOOKUP, 32'hFFFFFFFF, 32'h00000000, 4'd0,  1'b0, '0},
      '{CMD_LOOKUP, 32'h7FFFFFFF, 32'h00000000, 4'd0,  1'b0, '0}
   };

   longest_prefix_route_table_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // store one route in the shadow table; 0 when the table is full
   function automatic bit shadow_store(input logic [31:0] net, input logic [31:0] mask,
                                       input logic [3:0] card);
      if (shadow_count >= TABLE_DEPTH) return 1'b0;
      shadow_net[shadow_count]  = net;
      shadow_mask[shadow_count] = mask;
      shadow_len[shadow_count]  = 6'($countones(mask));
      shadow_card[shadow_count] = card;
      shadow_count++;
      return 1'b1;
   endfunction

   // apply one command to the shadow table and return the answer it gives
   function automatic rsp_type route_table_predict(input req_type item);
      rsp_type     ans;
      logic [31:0] net;
      logic [5:0]  best;
      ans  = '0;
      best = '0;
      net  = item.address & item.mask_in;
      case (item.command)
         CMD_CLEAR: begin
            shadow_count = 0;
         end
         CMD_ADD: begin
            if (!shadow_store(net, item.mask_in, item.card)) ans.table_full = 1'b1;
            if (shadow_gateway != 32'h0 && (shadow_gateway & item.mask_in) == net) begin
               if (!shadow_store(32'h0, 32'h0, item.card)) ans.table_full = 1'b1;
            end
         end
         CMD_LOOKUP: begin
            for (int i = 0; i < shadow_count; i++) begin
               // strictly longer wins, so the earlier route keeps a tie
               if ((item.address & shadow_mask[i]) == shadow_net[i] &&
                   (!ans.found || shadow_len[i] > best)) begin
                  ans.found    = 1'b1;
                  best         = shadow_len[i];
                  ans.card_out = shadow_card[i];
               end
            end
         end
         default: ;
      endcase
      ans.entries_used = 6'(shadow_count);
      return ans;
   endfunction

   // offer one command, hold it until the transfer, then predict
   task automatic send_item(input req_type item, input bit typed, input rsp_type want);
      rsp_type ans;
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall !== 1'b0);
      ans = route_table_predict(item);
      pending_answers.push_back(typed ? want : ans);
      @(negedge clock);
   endtask

   task automatic wait_for_answers();
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(negedge clock);
   endtask

   // gateway writes only while nothing is in flight
   task automatic set_gateway(input logic [31:0] value);
      wait_for_answers();
      repeat (4) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      shadow_gateway = value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_random_phase(input int count);
      req_type     item;
      int          pick;
      int          k;
      logic [31:0] low;
      for (int n = 0; n < count; n++) begin
         item       = '0;
         pick       = $urandom_range(0, 999);
         item.card  = 4'($urandom_range(0, 15));
         item.mask_in = $urandom;
         k   = $urandom_range(0, 32);
         low = 32'((64'd1 << k) - 1);
         if ($urandom_range(0, 9) < 8)
            item.address = subnet_pool[$urandom_range(0, 7)] ^ ($urandom & low);
         else
            item.address = $urandom;
         if (pick < 10) begin
            item.command = CMD_CLEAR;
         end else if (pick < 50) begin
            item.command = CMD_NOP;
         end else if (pick < 400) begin
            item.command = CMD_ADD;
            // mostly contiguous prefixes, some with holes, some host routes
            pick = $urandom_range(0, 99);
            k    = $urandom_range(0, 32);
            if (pick < 75)
               item.mask_in = (k == 0) ? 32'h0 : (32'hFFFFFFFF << (32 - k));
            else if (pick < 90)
               item.mask_in = $urandom;
            else
               item.mask_in = 32'hFFFFFFFF;
         end else begin
            item.command = CMD_LOOKUP;
         end
         send_item(item, 1'b0, '0);
      end
   endtask

   // result checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_answers.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
               $display("unexpected result %h with nothing pending", rsp_data);
         end else begin
            want = pending_answers.pop_front();
            if (rsp_data.found !== want.found || rsp_data.card_out !== want.card_out ||
                rsp_data.table_full !== want.table_full ||
                rsp_data.entries_used !== want.entries_used) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("mismatch found/card/full/used: exp %b/%0d/%b/%0d got %b/%0d/%b/%0d",
                           want.found, want.card_out, want.table_full, want.entries_used,
                           rsp_data.found, rsp_data.card_out, rsp_data.table_full,
                           rsp_data.entries_used);
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // result side backpressure
   initial begin
      forever begin
         @(negedge clock);
         if (rx_hold_left > 0) begin
            rsp_stall <= 1'b1;
            rx_hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < rx_stall_pct);
         end
      end
   end

   initial begin
      logic [31:0] phase_gw  [5];
      int          phase_tx  [5];
      int          phase_rx  [5];
      req_type     item;

      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      rsp_stall      = 1'b0;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      shadow_count   = 0;
      shadow_gateway = '0;
      fail_count     = 0;
      quiet_cycles   = 0;
      tx_idle_pct    = 0;
      rx_stall_pct   = 0;
      rx_hold_left   = 0;
      for (int i = 0; i < 8; i++) subnet_pool[i] = $urandom;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part
      set_gateway(32'h0A000001);
      foreach (dir_rows[i]) begin
         item         = '0;
         item.command = dir_rows[i].cmd;
         item.address = dir_rows[i].addr;
         item.mask_in = dir_rows[i].mask;
         item.card    = dir_rows[i].card;
         send_item(item, dir_rows[i].typed, dir_rows[i].want);
      end

      // random phases: gateway, sender idle and receiver stall per phase
      phase_gw = '{32'h0, 32'hFFFFFFFF, subnet_pool[0] | 32'h1, $urandom,
                   subnet_pool[2] ^ 32'h5};
      phase_tx = '{0, 73, 0, 38, 0};
      phase_rx = '{0, 0, 73, 38, 0};
      for (int p = 0; p < 5; p++) begin
         set_gateway(phase_gw[p]);
         tx_idle_pct  = phase_tx[p];
         rx_stall_pct = phase_rx[p];
         if (p == 4) begin
            // long receiver hold-off while commands keep coming
            @(posedge clock);
            rx_hold_left = HOLD_CYCLES;
            @(negedge clock);
         end
         run_random_phase(PHASE_ITEMS);
         wait_for_answers();
      end

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
